// File: hw/rtl/pag_pkg.sv
// pag_pkg: shared types and constants for the phase anomaly guard.
// Used by pag_cfg, pag_step and phase_anomaly_guard; no dependencies.
package pag_pkg;

  localparam int unsigned PhaseW  = 12;
  localparam int unsigned CountW  = 8;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned GainW   = 13;
  localparam int unsigned QShift  = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OVER_LIMIT = 3'd0,
    CFG_CONFIRM    = 3'd1,
    CFG_RISE       = 3'd2,
    CFG_TOO_LOW    = 3'd3,
    CFG_GAIN       = 3'd4,
    CFG_INHIBIT    = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_RESET  = 1'b1
  } kind_e;

  // pot sits in bit 0, ready in bit 6
  typedef struct packed {
    logic ready;
    logic lock;
    logic inh;
    logic low;
    logic rise;
    logic warn;
    logic pot;
  } pag_flags_t;

  typedef struct packed {
    logic signed [PhaseW-1:0] over_limit;
    logic [CountW-1:0]        confirm;
    logic [PhaseW-1:0]        rise_thr;
    logic signed [PhaseW-1:0] too_low;
    logic [GainW-1:0]         gain;
    logic [HoldW-1:0]         inhibit;
  } pag_cfg_t;

  typedef struct packed {
    logic [CountW-1:0]        over_count;
    logic signed [PhaseW-1:0] baseline;
    logic [HoldW-1:0]         hold;
    pag_flags_t               flags;
  } pag_state_t;

endpackage

// File: hw/rtl/phase_anomaly_guard.sv
// phase_anomaly_guard: top level, input and result registers around pag_step.
// Depends on pag_pkg, pag_cfg and pag_step.
//
// Usage:
//  s_axis carries one beat per control tick: tuser is the kind (0 phase
//  sample, 1 baseline reset command), tdata[11:0] the signed phase in
//  tenths of a degree. Every input beat yields exactly one m_axis beat
//  holding the seven status flags and the 12-bit baseline after the step.
//  Path: a beat is taken into the input register, then the status update
//  is written into the result register. Throughput: one beat per cycle
//  while m_axis_tready is high; the whole update is one combinational pass
//  whose longest path is the 13 x 14 bit filter multiply, add and clamp.
//  Stalls: while m_axis_tready is low the result register holds and the
//  input register still takes one more beat; s_axis_tready then drops until
//  the result is taken. No beat is lost or repeated.
//  Configuration: cfg_we_i writes register cfg_index_i (0 over-limit
//  threshold, 1 confirm count, 2 rise threshold, 3 too-low threshold,
//  4 filter gain Q12, 5 inhibit ticks); other indexes are ignored. Write
//  only while no beat is in flight.
//  Reset: rst_ni clears the counters, baseline and flags and loads the
//  register defaults 1000, 3, 150, 100, 410, 50. Both channels empty.
module phase_anomaly_guard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pag_pkg::InDataW-1:0]   s_axis_tdata,   // [11:0] phase, [15:12] zero
  input  logic                          s_axis_tuser,   // [0] kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] vessel_off, [1] limit_alert, [2] phase_jump, [3] too_low,
  // [4] power_hold, [5] base_frozen, [6] baseline_ready,
  // [18:7] baseline_value, [23:19] zero
  output logic [pag_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [pag_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pag_pkg::CfgW-1:0]      cfg_wdata_i
);

  pag_pkg::pag_cfg_t   cfg;
  pag_pkg::pag_state_t state_q, state_d;

  logic                              in_valid_q;
  logic                              in_kind_q;
  logic signed [pag_pkg::PhaseW-1:0] in_phase_q;
  logic                              out_valid_q;
  logic [pag_pkg::OutDataW-1:0]      out_data_q;
  logic                              advance;   // result register can load
  logic                              fire;      // beat moves into result stage

  pag_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  pag_step u_step (
    .kind_i  (in_kind_q),
    .phase_i (in_phase_q),
    .cfg_i   (cfg),
    .cur_i   (state_q),
    .nxt_o   (state_d)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q  <= s_axis_tuser;
      in_phase_q <= s_axis_tdata[pag_pkg::PhaseW-1:0];
    end
  end

  // status state, updated once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {5'd0, state_d.baseline, state_d.flags};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  // an active hold always shows as inhibit
  a_hold_inh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hold != '0 |-> state_q.flags.inh)
    else $error("hold running without inhibit flag");

  // warning and confirmation are exclusive
  a_warn_pot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.flags.warn && state_q.flags.pot))
    else $error("warning and confirmed removal both set");

  // sudden rise and baseline lock are set and cleared together
  a_rise_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.flags.rise == state_q.flags.lock)
    else $error("rise and lock flags disagree");

  // a beat leaving the input stage lands in the result register
  a_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("beat lost between stages");
`endif

endmodule

// File: hw/rtl/pag_cfg.sv
// pag_cfg: configuration register file, write-only.
// Depends on pag_pkg.
module pag_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [pag_pkg::CfgIdxW-1:0] index_i,
  input  logic [pag_pkg::CfgW-1:0]    wdata_i,
  output pag_pkg::pag_cfg_t           cfg_o
);

  pag_pkg::pag_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (pag_pkg::cfg_idx_e'(index_i))
        pag_pkg::CFG_OVER_LIMIT: cfg_d.over_limit = wdata_i[pag_pkg::PhaseW-1:0];
        pag_pkg::CFG_CONFIRM:    cfg_d.confirm    = wdata_i[pag_pkg::CountW-1:0];
        pag_pkg::CFG_RISE:       cfg_d.rise_thr   = wdata_i[pag_pkg::PhaseW-1:0];
        pag_pkg::CFG_TOO_LOW:    cfg_d.too_low    = wdata_i[pag_pkg::PhaseW-1:0];
        pag_pkg::CFG_GAIN:       cfg_d.gain       = wdata_i[pag_pkg::GainW-1:0];
        pag_pkg::CFG_INHIBIT:    cfg_d.inhibit    = wdata_i[pag_pkg::HoldW-1:0];
        default:                 cfg_d = cfg_q;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.over_limit <= 12'sd1000;
      cfg_q.confirm    <= 8'd3;
      cfg_q.rise_thr   <= 12'd150;
      cfg_q.too_low    <= 12'sd100;
      cfg_q.gain       <= 13'd410;
      cfg_q.inhibit    <= 16'd50;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/pag_step.sv
// pag_step: next-state logic for one beat (counter, filter, hold).
// Depends on pag_pkg.
module pag_step (
  input  logic                              kind_i,
  input  logic signed [pag_pkg::PhaseW-1:0] phase_i,
  input  pag_pkg::pag_cfg_t                 cfg_i,
  input  pag_pkg::pag_state_t               cur_i,
  output pag_pkg::pag_state_t               nxt_o
);

  logic [pag_pkg::CountW-1:0]        oc;
  logic signed [pag_pkg::PhaseW-1:0] base0;
  logic signed [pag_pkg::PhaseW-1:0] base1;
  logic [pag_pkg::PhaseW:0]          delta;   // 13-bit signed difference
  logic                              rise_hit;
  logic [26:0]                       prod;
  logic [14:0]                       stepv;
  logic [15:0]                       sum;
  logic signed [pag_pkg::PhaseW-1:0] filt;
  logic [pag_pkg::HoldW-1:0]         hold;
  pag_pkg::pag_flags_t               fl;

  always_comb begin
    nxt_o = cur_i;
    fl    = cur_i.flags;
    oc    = cur_i.over_count;
    hold  = cur_i.hold;

    base0    = cur_i.flags.ready ? cur_i.baseline : phase_i;
    delta    = {phase_i[11], phase_i} - {base0[11], base0};
    rise_hit = $signed({delta[12], delta}) > $signed({2'b00, cfg_i.rise_thr});

    // Q12 low-pass step, floor shift taken from the product's upper bits
    prod  = {{14{delta[12]}}, delta} * {14'd0, cfg_i.gain};
    stepv = prod[26:12];
    sum   = {{4{base0[11]}}, base0} + {stepv[14], stepv};
    if ($signed(sum) > 16'sd2047) begin
      filt = 12'sd2047;
    end else if ($signed(sum) < -16'sd2048) begin
      filt = -12'sd2048;
    end else begin
      filt = sum[11:0];
    end
    base1 = base0;

    if (kind_i == pag_pkg::KIND_RESET) begin
      nxt_o.baseline = phase_i;
      nxt_o.hold     = '0;
      nxt_o.flags    = '0;
      nxt_o.flags.ready = 1'b1;
    end else begin
      if (phase_i >= cfg_i.over_limit) begin
        if (oc != {pag_pkg::CountW{1'b1}}) begin
          oc = oc + 1'b1;
        end
        if (oc >= cfg_i.confirm) begin
          fl.pot = 1'b1;
        end
      end else begin
        oc     = '0;
        fl.pot = 1'b0;
      end
      fl.ready = 1'b1;

      if (!fl.lock && rise_hit) begin
        fl.lock = 1'b1;
        fl.rise = 1'b1;
        fl.inh  = 1'b1;
        hold    = cfg_i.inhibit;
      end
      if (!fl.lock) begin
        base1 = filt;
      end

      if (phase_i < cfg_i.too_low) begin
        fl.low = 1'b1;
        fl.inh = 1'b1;
        hold   = cfg_i.inhibit;
      end else begin
        fl.low = 1'b0;
      end

      // hold expiry; when locked the baseline was not filtered this beat,
      // so the rise test against base0 still applies
      if (hold != '0) begin
        hold = hold - 1'b1;
        if (hold == '0) begin
          fl.inh = 1'b0;
          if (fl.lock) begin
            if (!rise_hit) begin
              fl.lock = 1'b0;
              fl.rise = 1'b0;
              base1   = phase_i;
            end else begin
              fl.inh = 1'b1;
              hold   = cfg_i.inhibit;
            end
          end
        end
      end

      fl.warn = (oc != '0) && !fl.pot;

      nxt_o.over_count = oc;
      nxt_o.baseline   = base1;
      nxt_o.hold       = hold;
      nxt_o.flags      = fl;
    end
  end

endmodule

// File: dv/pag_checker.sv
// pag_checker: watches the sample and status channels of phase_anomaly_guard,
// predicts each status beat and compares it field by field. Depends on pag_pkg.
module pag_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [pag_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [pag_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [pag_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pag_pkg::CfgW-1:0]     cfg_wdata_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // status beat as it sits on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [pag_pkg::OutDataW-pag_pkg::PhaseW-8:0] pad;
    logic signed [pag_pkg::PhaseW-1:0]            base;
    pag_pkg::pag_flags_t                          flags;
  } guard_status_t;

  localparam string FlagName [7] = '{"vessel_off", "limit_alert", "phase_jump",
                                     "too_low", "power_hold", "base_frozen",
                                     "baseline_ready"};

  pag_pkg::pag_cfg_t   cfg;
  int unsigned         over_cnt;
  int                  base;
  int unsigned         hold;
  pag_pkg::pag_flags_t flags;
  guard_status_t       pending_status_q [$];
  int                  mismatch_cnt;

  function automatic void open_hold();
    flags.inh = 1'b1;
    hold      = cfg.inhibit;
  endfunction

  function automatic guard_status_t advance_guard(logic kind,
                                                  logic signed [pag_pkg::PhaseW-1:0] ph_in);
    int            ph;
    int            delta;
    int            ol;
    int            tl;
    int            rise;
    int            gain;
    longint        nb;
    guard_status_t res;
    ph   = ph_in;
    ol   = cfg.over_limit;
    tl   = cfg.too_low;
    rise = cfg.rise_thr;
    gain = cfg.gain;
    if (kind == pag_pkg::KIND_RESET) begin
      base        = ph;
      hold        = 0;
      flags       = '0;
      flags.ready = 1'b1;
    end else begin
      if (ph >= ol) begin
        if (over_cnt < 255) over_cnt++;
        if (over_cnt >= cfg.confirm) flags.pot = 1'b1;
      end else begin
        over_cnt  = 0;
        flags.pot = 1'b0;
      end
      if (!flags.ready) begin
        base        = ph;
        flags.ready = 1'b1;
      end
      delta = ph - base;
      if (!flags.lock && delta > rise) begin
        flags.lock = 1'b1;
        flags.rise = 1'b1;
        open_hold();
      end
      // low-pass step, floor of delta * gain / 4096, then clamp to 12 bits
      if (!flags.lock) begin
        nb = base + ((longint'(delta) * gain) >>> pag_pkg::QShift);
        if (nb > 2047) nb = 2047;
        else if (nb < -2048) nb = -2048;
        base = int'(nb);
      end
      if (ph < tl) begin
        flags.low = 1'b1;
        open_hold();
      end else begin
        flags.low = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        if (hold == 0) begin
          flags.inh = 1'b0;
          if (flags.lock) begin
            if (ph - base <= rise) begin
              flags.lock = 1'b0;
              flags.rise = 1'b0;
              base       = ph;
            end else begin
              open_hold();
            end
          end
        end
      end
      flags.warn = (over_cnt > 0) && !flags.pot;
    end
    res.pad   = '0;
    res.base  = base[pag_pkg::PhaseW-1:0];
    res.flags = flags;
    return res;
  endfunction

  function automatic void compare_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: status field %s mismatch, expected %0d, got %0d",
                 $realtime, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    guard_status_t exp_s;
    guard_status_t got_s;
    if (!rst_ni) begin
      cfg.over_limit = 12'sd1000;
      cfg.confirm    = 8'd3;
      cfg.rise_thr   = 12'd150;
      cfg.too_low    = 12'sd100;
      cfg.gain       = 13'd410;
      cfg.inhibit    = 16'd50;
      over_cnt       = 0;
      base           = 0;
      hold           = 0;
      flags          = '0;
      mismatch_cnt   = 0;
      pending_status_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          pag_pkg::CFG_OVER_LIMIT: cfg.over_limit = cfg_wdata_i[pag_pkg::PhaseW-1:0];
          pag_pkg::CFG_CONFIRM:    cfg.confirm    = cfg_wdata_i[pag_pkg::CountW-1:0];
          pag_pkg::CFG_RISE:       cfg.rise_thr   = cfg_wdata_i[pag_pkg::PhaseW-1:0];
          pag_pkg::CFG_TOO_LOW:    cfg.too_low    = cfg_wdata_i[pag_pkg::PhaseW-1:0];
          pag_pkg::CFG_GAIN:       cfg.gain       = cfg_wdata_i[pag_pkg::GainW-1:0];
          pag_pkg::CFG_INHIBIT:    cfg.inhibit    = cfg_wdata_i[pag_pkg::HoldW-1:0];
          default: ;
        endcase
      end
      // status side first, so a beat can never match a sample taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got_s = m_axis_tdata;
        if (pending_status_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: status beat 0x%h with no sample outstanding",
                     $realtime, m_axis_tdata);
        end else begin
          exp_s = pending_status_q.pop_front();
          for (int i = 0; i < 7; i++)
            compare_field(FlagName[i], exp_s.flags[i], got_s.flags[i]);
          compare_field("baseline_value", exp_s.base, got_s.base);
          compare_field("padding", exp_s.pad, got_s.pad);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_status_q.push_back(
          advance_guard(s_axis_tuser, s_axis_tdata[pag_pkg::PhaseW-1:0]));
    end
    mismatch_count_o = mismatch_cnt;
    pending_o        = pending_status_q.size();
  end

endmodule

// File: dv/phase_anomaly_guard_tb.sv
// phase_anomaly_guard_tb: drives samples, baseline resets and register settings
// into phase_anomaly_guard; pag_checker does the prediction. Needs pag_pkg and the RTL.
module phase_anomaly_guard_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // longest quiet stretch of a good run is the deliberate hold-off plus a
  // few unlucky random stalls; the limit sits well above that
  localparam int StallLimit    = 4000;
  localparam int HoldOffCycles = 300;
  localparam int NumPhases     = 8;

  logic                         clk;
  logic                         rst_n;
  logic                         s_valid;
  logic                         s_ready;
  logic [pag_pkg::InDataW-1:0]  s_data;
  logic                         s_user;
  logic                         m_valid;
  logic                         m_ready;
  logic [pag_pkg::OutDataW-1:0] m_data;
  logic                         cfg_we;
  logic [pag_pkg::CfgIdxW-1:0]  cfg_index;
  logic [pag_pkg::CfgW-1:0]     cfg_wdata;

  int                mismatches;
  int                pending;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  bit                stall_req = 1'b0;
  pag_pkg::pag_cfg_t cur_cfg;
  int                level;

  phase_anomaly_guard u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata)
  );

  pag_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid    (s_valid),
    .s_axis_tready    (s_ready),
    .s_axis_tdata     (s_data),
    .s_axis_tuser     (s_user),
    .m_axis_tvalid    (m_valid),
    .m_axis_tready    (m_ready),
    .m_axis_tdata     (m_data),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // status side: random back-pressure, or a long hold-off on request so the
  // input register fills and s_axis_tready has to drop
  initial begin
    int stall_left;
    stall_left = 0;
    m_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req  = 1'b0;
        stall_left = HoldOffCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: ends the run once nothing has moved on either channel for too long
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready)) stalled = 0;
      else stalled++;
    end
    $display("phase_anomaly_guard test failed");
    $finish;
  end

  function automatic int clamp_phase(int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic pag_pkg::pag_cfg_t make_cfg(int ol, int cc, int rt, int tl, int g,
                                                 int ih);
    pag_pkg::pag_cfg_t c;
    c.over_limit = ol[pag_pkg::PhaseW-1:0];
    c.confirm    = cc[pag_pkg::CountW-1:0];
    c.rise_thr   = rt[pag_pkg::PhaseW-1:0];
    c.too_low    = tl[pag_pkg::PhaseW-1:0];
    c.gain       = g[pag_pkg::GainW-1:0];
    c.inhibit    = ih[pag_pkg::HoldW-1:0];
    return c;
  endfunction

  // register settings per phase; the extremes include zero confirm (instant
  // confirmation), zero hold (never expires) and gains over unity (baseline
  // overshoot, clamped)
  function automatic pag_pkg::pag_cfg_t phase_cfg(int p);
    case (p)
      0:       return make_cfg(1000, 3, 150, 100, 410, 50);
      1:       return make_cfg(-2048, 255, 0, -2048, 8191, 1);
      2:       return make_cfg(2047, 0, 4095, 2047, 0, 0);
      3:       return make_cfg(500, 1, 300, -500, 4096, 5);
      4:       return make_cfg(0, 10, 50, -100, 6000, 65535);
      5:       return make_cfg(200, 2, 100, 0, 2048, 3);
      6:       return make_cfg(int'($urandom), int'($urandom), int'($urandom),
                               int'($urandom), int'($urandom_range(8191)),
                               int'($urandom_range(40, 1)));
      default: return make_cfg(-1, 3, 150, 100, 410, 8);
    endcase
  endfunction

  // one input beat; valid may stay high into the next beat, never toggled in one step
  task automatic offer_beat(pag_pkg::kind_e kind, int ph);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {{(pag_pkg::InDataW-pag_pkg::PhaseW){1'b0}}, ph[pag_pkg::PhaseW-1:0]};
    do @(posedge clk); while (!s_ready);
  endtask

  // drop valid and let every outstanding status beat come back
  task automatic wait_drained();
    @(negedge clk);
    s_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(logic [pag_pkg::CfgIdxW-1:0] idx, logic [pag_pkg::CfgW-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
  endtask

  task automatic load_settings(pag_pkg::pag_cfg_t c);
    // unused indexes first, with junk; the block must ignore them
    for (int idx = int'(pag_pkg::CFG_INHIBIT) + 1; idx < (1 << pag_pkg::CfgIdxW); idx++)
      put_reg(idx[pag_pkg::CfgIdxW-1:0], pag_pkg::CfgW'($urandom));
    put_reg(pag_pkg::CFG_OVER_LIMIT,
            {{(pag_pkg::CfgW-pag_pkg::PhaseW){c.over_limit[pag_pkg::PhaseW-1]}},
             c.over_limit});
    put_reg(pag_pkg::CFG_CONFIRM, {{(pag_pkg::CfgW-pag_pkg::CountW){1'b0}}, c.confirm});
    put_reg(pag_pkg::CFG_RISE,    {{(pag_pkg::CfgW-pag_pkg::PhaseW){1'b0}}, c.rise_thr});
    put_reg(pag_pkg::CFG_TOO_LOW,
            {{(pag_pkg::CfgW-pag_pkg::PhaseW){c.too_low[pag_pkg::PhaseW-1]}}, c.too_low});
    put_reg(pag_pkg::CFG_GAIN,    {{(pag_pkg::CfgW-pag_pkg::GainW){1'b0}}, c.gain});
    put_reg(pag_pkg::CFG_INHIBIT, c.inhibit);
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  // mostly a slowly drifting phase with rises and pulls towards the two
  // thresholds, so runs, locks and hold expiries actually happen; the rest is
  // noise, rail values and baseline resets
  task automatic play_random(int n);
    int             r;
    int             ph;
    pag_pkg::kind_e kind;
    for (int i = 0; i < n; i++) begin
      r    = $urandom_range(99);
      kind = pag_pkg::KIND_SAMPLE;
      if (r < 3) begin
        kind  = pag_pkg::KIND_RESET;
        ph    = $signed(pag_pkg::PhaseW'($urandom));
        level = ph;
      end else if (r < 10) begin
        ph = $signed(pag_pkg::PhaseW'($urandom));
      end else if (r < 14) begin
        ph = $urandom_range(1) ? 2047 : -2048;
      end else if (r < 20) begin
        if ($urandom_range(1)) level = cur_cfg.over_limit;
        else level = cur_cfg.too_low;
        level = clamp_phase(level + int'($urandom_range(20)) - 10);
        ph    = level;
      end else if (r < 28) begin
        level = clamp_phase(level + int'($urandom_range(500)) - 100);
        ph    = level;
      end else begin
        level = clamp_phase(level + int'($urandom_range(60)) - 30);
        ph    = level;
      end
      offer_beat(kind, ph);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    s_valid       = 1'b0;
    s_data        = '0;
    s_user        = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    send_idle_pct = 33;
    recv_idle_pct = 64;
    level         = 0;
    cur_cfg       = make_cfg(1000, 3, 150, 100, 410, 50);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed beats on the reset settings
    offer_beat(pag_pkg::KIND_SAMPLE, 500);    // first sample captures the baseline
    offer_beat(pag_pkg::KIND_SAMPLE, 520);
    offer_beat(pag_pkg::KIND_SAMPLE, 1000);   // over limit: warning
    offer_beat(pag_pkg::KIND_SAMPLE, 1000);
    offer_beat(pag_pkg::KIND_SAMPLE, 1000);   // third in a row confirms
    offer_beat(pag_pkg::KIND_SAMPLE, 999);    // just under: run and confirmation cleared
    offer_beat(pag_pkg::KIND_SAMPLE, 2047);   // over limit again, warning; baseline still locked, hold running
    offer_beat(pag_pkg::KIND_SAMPLE, -2048);  // too low renews the hold
    offer_beat(pag_pkg::KIND_SAMPLE, 99);
    offer_beat(pag_pkg::KIND_SAMPLE, 100);    // too-low boundary
    offer_beat(pag_pkg::KIND_RESET, 0);       // baseline reset command
    offer_beat(pag_pkg::KIND_SAMPLE, -1);     // negative filter step rounds down
    offer_beat(pag_pkg::KIND_SAMPLE, 1);
    offer_beat(pag_pkg::KIND_RESET, -2048);
    offer_beat(pag_pkg::KIND_SAMPLE, 2047);   // largest positive delta
    offer_beat(pag_pkg::KIND_RESET, 2047);
    offer_beat(pag_pkg::KIND_SAMPLE, -2048);  // largest negative delta
    offer_beat(pag_pkg::KIND_RESET, -1);
    offer_beat(pag_pkg::KIND_SAMPLE, 1000);   // over limit after the reset command: new run, warning
    offer_beat(pag_pkg::KIND_SAMPLE, 1000);

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      load_settings(phase_cfg(p));
      if (p < 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 64;
      end else if (p < 6) begin
        send_idle_pct = 64;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == NumPhases - 1) stall_req = 1'b1;
      // phase 1 has every sample over the limit: long enough to saturate the run count
      play_random(p == 1 ? 320 : 170);
    end
    wait_drained();

    if (mismatches == 0 && pending == 0) begin
      $display("phase_anomaly_guard test passed");
    end else begin
      $display("phase_anomaly_guard test failed");
    end
    $finish;
  end

endmodule
